### hw/rtl/kmnca_pkg.sv
// Shared constants, types and arithmetic helpers for the k-means assignment block.
package kmnca_pkg;

  localparam int MAX_DIMENSIONS = 64;
  localparam int MAX_CENTERS    = 256;
  localparam int COORD_BITS     = 16;

  localparam int DIM_BITS    = $clog2(MAX_DIMENSIONS);
  localparam int CENTER_BITS = $clog2(MAX_CENTERS);
  localparam int ADDR_BITS   = DIM_BITS + CENTER_BITS;
  localparam int DIFF_BITS   = COORD_BITS + 1;
  localparam int SQ_BITS     = 2 * DIFF_BITS;
  localparam int DIST_BITS   = 39;
  localparam int SUM_BITS    = 48;
  localparam int CNT_BITS    = 32;

  localparam logic [DIST_BITS-1:0] DIST_MAX = {DIST_BITS{1'b1}};
  localparam logic [SUM_BITS-1:0]  SUM_MAX  = {1'b0, {(SUM_BITS-1){1'b1}}};
  localparam logic [SUM_BITS-1:0]  SUM_MIN  = {1'b1, {(SUM_BITS-1){1'b0}}};
  localparam logic [CNT_BITS-1:0]  CNT_MAX  = {CNT_BITS{1'b1}};

  localparam logic [1:0] OP_LOAD   = 2'd0;
  localparam logic [1:0] OP_RECORD = 2'd1;
  localparam logic [1:0] OP_CLEAR  = 2'd2;
  localparam logic [1:0] OP_READ   = 2'd3;

  localparam logic KIND_ASSIGN = 1'b0;
  localparam logic KIND_READ   = 1'b1;

  localparam logic [0:0] REG_DIMS    = 1'b0;
  localparam logic [0:0] REG_CENTERS = 1'b1;

  typedef struct packed {
    logic                         cen_we;
    logic [ADDR_BITS-1:0]         cen_waddr;
    logic signed [COORD_BITS-1:0] cen_wdata;
    logic [ADDR_BITS-1:0]         cen_raddr;
    logic                         rec_we;
    logic [DIM_BITS-1:0]          rec_waddr;
    logic signed [COORD_BITS-1:0] rec_wdata;
    logic [DIM_BITS-1:0]          rec_raddr;
  } cent_req_t;

  typedef struct packed {
    logic                       sum_we;
    logic [ADDR_BITS-1:0]       sum_waddr;
    logic signed [SUM_BITS-1:0] sum_wdata;
    logic                       sum_re;
    logic [ADDR_BITS-1:0]       sum_raddr;
    logic                       cnt_we;
    logic [CENTER_BITS-1:0]     cnt_waddr;
    logic [CNT_BITS-1:0]        cnt_wdata;
    logic                       cnt_re;
    logic [CENTER_BITS-1:0]     cnt_raddr;
  } accum_req_t;

  function automatic logic [CNT_BITS-1:0] sat_inc(input logic [CNT_BITS-1:0] c);
    return (c == CNT_MAX) ? c : c + 1'b1;
  endfunction

  function automatic logic [SUM_BITS-1:0] sum_add(input logic [SUM_BITS-1:0] s,
                                                  input logic [COORD_BITS-1:0] v);
    logic [SUM_BITS:0] t;
    t = {s[SUM_BITS-1], s} + {{(SUM_BITS+1-COORD_BITS){v[COORD_BITS-1]}}, v};
    if (t[SUM_BITS] != t[SUM_BITS-1]) begin
      return t[SUM_BITS] ? SUM_MIN : SUM_MAX;
    end
    return t[SUM_BITS-1:0];
  endfunction

  function automatic logic [DIST_BITS-1:0] dist_add(input logic [DIST_BITS-1:0] a,
                                                    input logic [SQ_BITS-1:0] q);
    logic [DIST_BITS:0] t;
    t = {1'b0, a} + {{(DIST_BITS+1-SQ_BITS){1'b0}}, q};
    return t[DIST_BITS] ? DIST_MAX : t[DIST_BITS-1:0];
  endfunction

endpackage

### hw/rtl/kmeans_nearest_center_accumulate.sv
// K-means nearest-centroid assignment with saturating per-cluster accumulators.
//
// Input stream s_*: tuser carries op (load centroid coordinate, record coordinate,
// clear accumulators, read accumulators); tdata carries the coordinate and addresses.
// Output stream m_*: tuser is the result kind; tdata holds the assignment or readback.
// Config port cfg_*: index 0 dimension_count, index 1 center_count; always ready,
// write only while the block is idle. Writing dimension_count restarts the record.
// A centroid load or a non-final record coordinate is stored and the block
// stays idle. The final coordinate of a record runs a distance sweep through
// the centroid memory, one coordinate per cycle on one multiply-accumulate
// lane, then a sum update pass and a count update. A readback reads the sum
// and count memories. A clear sweeps the sum and count memories to zero.
// After reset the block sweeps the sum and count memories to zero before
// s_tready rises. A result waits in the output register while m_tready is
// low; the block keeps accepting transfers until it needs to deliver the
// next result, and holds there until the register frees.
module kmeans_nearest_center_accumulate (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // [7:0] center_index, [13:8] dim_index, [29:14] coord_value,
  // [38:30] previous_center, [39] zero
  input  logic [39:0]  s_tdata,
  // [1:0] op
  input  logic [1:0]   s_tuser,
  output logic         m_tvalid,
  input  logic         m_tready,
  // [7:0] center_id, [8] changed, [47:9] distance, [95:48] sum_value,
  // [127:96] member_count, [159:128] changed_total
  output logic [159:0] m_tdata,
  // [0] result_kind
  output logic [0:0]   m_tuser,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [0:0]   cfg_index,
  input  logic [8:0]   cfg_data
);

  localparam int DB = kmnca_pkg::DIM_BITS;
  localparam int CB = kmnca_pkg::CENTER_BITS;
  localparam int AB = kmnca_pkg::ADDR_BITS;
  localparam int XB = kmnca_pkg::COORD_BITS;

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_CLEAR = 9'b000000010,
    S_DIST  = 9'b000000100,
    S_DRAIN = 9'b000001000,
    S_UPD   = 9'b000010000,
    S_UFIN  = 9'b000100000,
    S_RD    = 9'b001000000,
    S_RDOUT = 9'b010000000,
    S_UWAIT = 9'b100000000
  } state_t;

  state_t state, state_next;

  logic [6:0]  dimension_count;
  logic [8:0]  center_count;
  logic [6:0]  coord_position;
  logic [DB-1:0] dims_m1;
  logic [CB-1:0] cent_m1;

  logic [CB-1:0] in_center;
  logic [DB-1:0] in_dim;
  logic signed [XB-1:0] in_coord;
  logic [8:0]  in_prev;
  logic [1:0]  in_op;
  logic        s_fire;

  logic [CB-1:0] req_center;
  logic [DB-1:0] req_dim;
  logic [8:0]    req_prev;
  logic [AB-1:0] clr_addr;

  logic [CB-1:0] cidx;
  logic [DB-1:0] didx;
  logic          v1, first1, last1;
  logic [CB-1:0] c1;
  logic          v2, first2, last2;
  logic [CB-1:0] c2;
  logic [kmnca_pkg::SQ_BITS-1:0] sq2;
  logic [kmnca_pkg::DIST_BITS-1:0] acc, acc_next, best_dist;
  logic [CB-1:0] best_c;

  logic          u1;
  logic [AB-1:0] u1_addr;

  logic [kmnca_pkg::CNT_BITS-1:0] change_counter;

  kmnca_pkg::cent_req_t  creq;
  kmnca_pkg::accum_req_t areq;
  logic signed [XB-1:0] cen_rdata, rec_rdata;
  logic signed [kmnca_pkg::SUM_BITS-1:0] sum_rdata;
  logic [kmnca_pkg::CNT_BITS-1:0] cnt_rdata;

  logic signed [kmnca_pkg::DIFF_BITS-1:0] diff;
  logic [kmnca_pkg::DIFF_BITS-1:0] mag;
  logic [DB-1:0] wpos;
  logic          rec_last;
  logic          slot_free;
  logic [kmnca_pkg::CNT_BITS-1:0] new_count, new_total;
  logic          is_changed;

  assign in_center = s_tdata[7:0];
  assign in_dim    = s_tdata[13:8];
  assign in_coord  = s_tdata[29:14];
  assign in_prev   = s_tdata[38:30];
  assign in_op     = s_tuser;
  assign s_tready  = (state == S_IDLE);
  assign s_fire    = s_tvalid && s_tready;
  assign cfg_ready = 1'b1;
  assign slot_free = !m_tvalid || m_tready;

  always_comb begin
    if (dimension_count == 7'd0) begin
      dims_m1 = '0;
    end else if (dimension_count > 7'(kmnca_pkg::MAX_DIMENSIONS)) begin
      dims_m1 = DB'(kmnca_pkg::MAX_DIMENSIONS - 1);
    end else begin
      dims_m1 = DB'(dimension_count - 7'd1);
    end
    if (center_count == 9'd0) begin
      cent_m1 = '0;
    end else if (center_count > 9'(kmnca_pkg::MAX_CENTERS)) begin
      cent_m1 = CB'(kmnca_pkg::MAX_CENTERS - 1);
    end else begin
      cent_m1 = CB'(center_count - 9'd1);
    end
  end

  assign wpos     = (coord_position > {1'b0, dims_m1}) ? '0 : coord_position[DB-1:0];
  assign rec_last = (wpos == dims_m1);

  assign diff     = {rec_rdata[XB-1], rec_rdata} - {cen_rdata[XB-1], cen_rdata};
  assign mag      = diff[kmnca_pkg::DIFF_BITS-1] ? kmnca_pkg::DIFF_BITS'(-diff)
                                                 : kmnca_pkg::DIFF_BITS'(diff);
  assign acc_next = first2 ? kmnca_pkg::DIST_BITS'(sq2) : kmnca_pkg::dist_add(acc, sq2);

  assign new_count  = kmnca_pkg::sat_inc(cnt_rdata);
  assign is_changed = (req_prev != {1'b0, best_c});
  assign new_total  = is_changed ? kmnca_pkg::sat_inc(change_counter) : change_counter;

  always_comb begin
    creq = '0;
    creq.cen_we    = s_fire && (in_op == kmnca_pkg::OP_LOAD);
    creq.cen_waddr = {in_center, in_dim};
    creq.cen_wdata = in_coord;
    creq.cen_raddr = {cidx, didx};
    creq.rec_we    = s_fire && (in_op == kmnca_pkg::OP_RECORD);
    creq.rec_waddr = wpos;
    creq.rec_wdata = in_coord;
    creq.rec_raddr = didx;
  end

  always_comb begin
    areq = '0;
    areq.sum_raddr = {best_c, didx};
    areq.cnt_raddr = best_c;
    areq.sum_waddr = u1_addr;
    areq.sum_wdata = kmnca_pkg::sum_add(sum_rdata, rec_rdata);
    areq.sum_we    = u1;
    areq.cnt_waddr = best_c;
    areq.cnt_wdata = new_count;
    case (state)
      S_CLEAR: begin
        areq.sum_we    = 1'b1;
        areq.sum_waddr = clr_addr;
        areq.sum_wdata = '0;
        areq.cnt_we    = 1'b1;
        areq.cnt_waddr = clr_addr[CB-1:0];
        areq.cnt_wdata = '0;
      end
      S_UPD: begin
        areq.sum_re = 1'b1;
        areq.cnt_re = 1'b1;
      end
      S_UWAIT: begin
        areq.cnt_we = slot_free;
      end
      S_RD: begin
        areq.sum_re    = 1'b1;
        areq.cnt_re    = 1'b1;
        areq.sum_raddr = {req_center, req_dim};
        areq.cnt_raddr = req_center;
      end
      default: begin
      end
    endcase
  end

  kmnca_centroid_store u_cent (
    .clk       (clk),
    .req       (creq),
    .cen_rdata (cen_rdata),
    .rec_rdata (rec_rdata)
  );

  kmnca_accum_store u_accum (
    .clk       (clk),
    .req       (areq),
    .sum_rdata (sum_rdata),
    .cnt_rdata (cnt_rdata)
  );

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (s_fire) begin
          case (in_op)
            kmnca_pkg::OP_CLEAR:  state_next = S_CLEAR;
            kmnca_pkg::OP_READ:   state_next = S_RD;
            kmnca_pkg::OP_RECORD: state_next = rec_last ? S_DIST : S_IDLE;
            default:              state_next = S_IDLE;
          endcase
        end
      end
      S_CLEAR: begin
        if (clr_addr == {AB{1'b1}}) begin
          state_next = S_IDLE;
        end
      end
      S_DIST: begin
        if (didx == dims_m1 && cidx == cent_m1) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (!v1 && !v2) begin
          state_next = S_UPD;
        end
      end
      S_UPD: begin
        if (didx == dims_m1) begin
          state_next = S_UFIN;
        end
      end
      S_UFIN:  state_next = S_UWAIT;
      S_UWAIT: state_next = slot_free ? S_IDLE : S_UWAIT;
      S_RD:    state_next = S_RDOUT;
      S_RDOUT: state_next = slot_free ? S_IDLE : S_RDOUT;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_CLEAR;
      dimension_count <= 7'd1;
      center_count    <= 9'd1;
      coord_position  <= '0;
      change_counter  <= '0;
      clr_addr        <= '0;
      cidx            <= '0;
      didx            <= '0;
      v1              <= 1'b0;
      v2              <= 1'b0;
      u1              <= 1'b0;
      m_tvalid        <= 1'b0;
    end else begin
      state <= state_next;
      if ((state == S_UWAIT || state == S_RDOUT) && slot_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      if (state == S_CLEAR) begin
        clr_addr <= clr_addr + 1'b1;
      end
      if (s_fire) begin
        case (in_op)
          kmnca_pkg::OP_CLEAR: begin
            change_counter <= '0;
            clr_addr       <= '0;
          end
          kmnca_pkg::OP_RECORD: begin
            coord_position <= rec_last ? 7'd0 : {1'b0, wpos} + 7'd1;
            cidx           <= '0;
            didx           <= '0;
          end
          default: begin
          end
        endcase
      end
      v1 <= (state == S_DIST);
      v2 <= v1;
      u1 <= (state == S_UPD);
      if (state == S_DIST) begin
        if (didx == dims_m1) begin
          didx <= '0;
          cidx <= cidx + 1'b1;
        end else begin
          didx <= didx + 1'b1;
        end
      end
      if (state == S_DRAIN) begin
        didx <= '0;
      end
      if (state == S_UPD) begin
        didx <= didx + 1'b1;
      end
      if (state == S_UWAIT && slot_free) begin
        change_counter <= new_total;
      end
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == kmnca_pkg::REG_DIMS) begin
          dimension_count <= cfg_data[6:0];
          coord_position  <= '0;
        end else begin
          center_count <= cfg_data;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_fire) begin
      req_center <= in_center;
      req_dim    <= in_dim;
      req_prev   <= in_prev;
    end
    first1 <= (didx == '0);
    last1  <= (didx == dims_m1);
    c1     <= cidx;
    first2 <= first1;
    last2  <= last1;
    c2     <= c1;
    sq2    <= mag * mag;
    u1_addr <= {best_c, didx};
    if (v2) begin
      acc <= acc_next;
      if (last2 && (c2 == '0 || acc_next < best_dist)) begin
        best_dist <= acc_next;
        best_c    <= c2;
      end
    end
    if (state == S_UWAIT && slot_free) begin
      m_tuser[0]      <= kmnca_pkg::KIND_ASSIGN;
      m_tdata[7:0]    <= best_c;
      m_tdata[8]      <= is_changed;
      m_tdata[47:9]   <= best_dist;
      m_tdata[95:48]  <= '0;
      m_tdata[127:96] <= new_count;
      m_tdata[159:128] <= new_total;
    end
    if (state == S_RDOUT && slot_free) begin
      m_tuser[0]      <= kmnca_pkg::KIND_READ;
      m_tdata[7:0]    <= req_center;
      m_tdata[8]      <= 1'b0;
      m_tdata[47:9]   <= '0;
      m_tdata[95:48]  <= sum_rdata;
      m_tdata[127:96] <= cnt_rdata;
      m_tdata[159:128] <= change_counter;
    end
  end

endmodule

### hw/rtl/kmnca_centroid_store.sv
// Centroid coordinate memory and record coordinate buffer, each with a registered read.
module kmnca_centroid_store (
  input  logic                                   clk,
  input  kmnca_pkg::cent_req_t                   req,
  output logic signed [kmnca_pkg::COORD_BITS-1:0] cen_rdata,
  output logic signed [kmnca_pkg::COORD_BITS-1:0] rec_rdata
);

  logic signed [kmnca_pkg::COORD_BITS-1:0] cen_mem [kmnca_pkg::MAX_CENTERS*kmnca_pkg::MAX_DIMENSIONS];
  logic signed [kmnca_pkg::COORD_BITS-1:0] rec_mem [kmnca_pkg::MAX_DIMENSIONS];

  always_ff @(posedge clk) begin
    if (req.cen_we) begin
      cen_mem[req.cen_waddr] <= req.cen_wdata;
    end
    cen_rdata <= cen_mem[req.cen_raddr];
  end

  always_ff @(posedge clk) begin
    if (req.rec_we) begin
      rec_mem[req.rec_waddr] <= req.rec_wdata;
    end
    rec_rdata <= rec_mem[req.rec_raddr];
  end

endmodule

### hw/rtl/kmnca_accum_store.sv
// Per-centroid coordinate sum memory and member count memory, each with a registered read.
module kmnca_accum_store (
  input  logic                                 clk,
  input  kmnca_pkg::accum_req_t                req,
  output logic signed [kmnca_pkg::SUM_BITS-1:0] sum_rdata,
  output logic [kmnca_pkg::CNT_BITS-1:0]        cnt_rdata
);

  logic signed [kmnca_pkg::SUM_BITS-1:0] sum_mem [kmnca_pkg::MAX_CENTERS*kmnca_pkg::MAX_DIMENSIONS];
  logic [kmnca_pkg::CNT_BITS-1:0]        cnt_mem [kmnca_pkg::MAX_CENTERS];

  always_ff @(posedge clk) begin
    if (req.sum_we) begin
      sum_mem[req.sum_waddr] <= req.sum_wdata;
    end
    if (req.sum_re) begin
      sum_rdata <= sum_mem[req.sum_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (req.cnt_we) begin
      cnt_mem[req.cnt_waddr] <= req.cnt_wdata;
    end
    if (req.cnt_re) begin
      cnt_rdata <= cnt_mem[req.cnt_raddr];
    end
  end

endmodule
